[src/itcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcf_pkg
// Shared widths, register indexes and the CORDIC angle table for the tilt
// filter.
// ----------------------------------------------------------------------------
package itcf_pkg;

    localparam int CORD_W = 28;     // CORDIC x/y datapath
    localparam int Z_W    = 26;     // CORDIC angle, Q16 degrees
    localparam int DIV_NW = 25;     // divider numerator / quotient
    localparam int DIV_DW = 8;      // divider denominator

    localparam logic signed [Z_W-1:0] ANG90_Q16 = 26'sd5898240;

    localparam logic [7:0] REG_CAL_COUNT  = 8'd0;
    localparam logic [7:0] REG_GRAVITY    = 8'd1;
    localparam logic [7:0] REG_GYRO_FS    = 8'd2;
    localparam logic [7:0] REG_ALPHA      = 8'd3;

    // atan(2^-i) in degrees, Q16, rounded
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] r;
        case (idx)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

[src/itcf_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcf_cordic
// Iterative vectoring CORDIC, atan2(y, x) in Q16 degrees, one rotation per
// cycle.
// ----------------------------------------------------------------------------
module itcf_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [16:0]              i_y,
    input  logic signed [16:0]              i_x,
    output logic                            o_done,
    output logic signed [itcf_pkg::Z_W-1:0] o_z
);
    import itcf_pkg::*;

    localparam int IW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

    logic                     r_busy;
    logic                     r_done;
    logic [IW-1:0]            r_i;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [Z_W-1:0]    r_z;
    logic signed [CORD_W-1:0] n_xs;
    logic signed [CORD_W-1:0] n_ys;
    logic signed [CORD_W-1:0] n_dx;
    logic signed [CORD_W-1:0] n_dy;
    logic signed [Z_W-1:0]    n_at;

    always_comb begin
        n_xs = CORD_W'(i_x) <<< 8;
        n_ys = CORD_W'(i_y) <<< 8;
        n_dx = r_x >>> r_i;
        n_dy = r_y >>> r_i;
        n_at = $signed(Z_W'(atan_q16(5'(r_i))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_x == 17'sd0 && i_y == 17'sd0) begin
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    // pre-rotate left half plane by +/-90
                    if (i_x < 0) begin
                        if (i_y >= 0) begin
                            r_x <= n_ys;
                            r_y <= -n_xs;
                            r_z <= ANG90_Q16;
                        end else begin
                            r_x <= -n_ys;
                            r_y <= n_xs;
                            r_z <= -ANG90_Q16;
                        end
                    end else begin
                        r_x <= n_xs;
                        r_y <= n_ys;
                        r_z <= '0;
                    end
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + n_dy;
                    r_y <= r_y - n_dx;
                    r_z <= r_z + n_at;
                end else begin
                    r_x <= r_x - n_dy;
                    r_y <= r_y + n_dx;
                    r_z <= r_z - n_at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == IW'(ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;

endmodule

[src/itcf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itcf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [itcf_pkg::DIV_NW-1:0]   i_num,
    input  logic [itcf_pkg::DIV_DW-1:0]   i_den,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [itcf_pkg::DIV_NW-1:0]   o_quo
);
    import itcf_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   n_trial;
    logic              n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[DIV_NW-1]};
        n_ge    = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_ge ? DIV_DW'(n_trial - {1'b0, r_den}) : DIV_DW'(n_trial);
                r_quo <= {r_quo[DIV_NW-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[src/imu_tilt_complementary_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Offset calibration, CORDIC accel tilt, gyro integration and complementary
// filter for pitch and roll; angles in 1/128 degree.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    word
//  in        sink       i_in_valid / o_in_stall      six raw samples + elapsed_ms
//  out       source     o_out_valid / i_out_stall    six angles
//  cfg       sink       i_cfg_valid / o_cfg_ready    index + data
//
//  Calibration sample: one summing step, then one serial divide per channel.
//  Filter sample: two CORDIC runs, two gyro steps and two fused steps; the
//  CORDIC and the gyro step reduction loops dominate.
//  One word is worked at a time; o_in_stall is high until it is finished.
//  The result sits in an output register, so a stalled output only holds the
//  block once the next result is ready.
//  Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic        [15:0] i_elapsed_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_pitch_accel,
    output logic signed [15:0] o_roll_accel,
    output logic signed [15:0] o_pitch_gyro,
    output logic signed [15:0] o_roll_gyro,
    output logic signed [15:0] o_pitch_fused,
    output logic signed [15:0] o_roll_fused,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [7:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);
    import itcf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CAL_SUM, S_CAL_DIV, S_CAL_WAIT, S_CORR, S_ACC_GO, S_ACC_WAIT,
        S_G_M1, S_G_M2, S_G_LOAD, S_G_R15, S_G_R125, S_F_T, S_F_M1, S_F_M2,
        S_F_M3, S_F_M4, S_F_SAT, S_DONE
    } t_state;

    t_state r_state;

    logic [7:0]  r_cal_count;
    logic [14:0] r_grav;
    logic [10:0] r_fs;
    logic [15:0] r_alpha;

    logic signed [15:0] r_s    [6];
    logic signed [16:0] r_c    [6];
    logic signed [23:0] r_sum  [6];
    logic signed [15:0] r_off  [6];
    logic signed [23:0] r_gang [2];
    logic signed [23:0] r_fang [2];
    logic signed [24:0] r_pa   [2];
    logic signed [35:0] r_step [2];
    logic signed [15:0] r_ar   [2];
    logic [15:0]        r_ms;
    logic [7:0]         r_cnt;
    logic [2:0]         r_idx;
    logic               r_k;
    logic               r_neg;
    logic signed [35:0] r_t;
    logic signed [49:0] r_prod;
    logic signed [55:0] r_acc;
    logic [43:0]        r_rm;
    logic [43:0]        r_qa;

    logic               r_out_valid;
    logic signed [15:0] r_o [6];

    logic signed [31:0] n_ma;
    logic signed [17:0] n_mb;
    logic signed [49:0] n_mp;
    logic [16:0]        n_beta;
    logic [7:0]         n_cal;
    logic signed [23:0] n_sum [6];
    logic signed [17:0] n_v;
    logic signed [25:0] n_wide;
    logic signed [49:0] n_pmag;
    logic signed [35:0] n_qmag;
    logic signed [24:0] n_off;
    logic signed [25:0] n_round;
    logic [43:0]        n_a15;
    logic [43:0]        n_a7;
    logic [43:0]        n_qfin;
    logic               n_out_load;

    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic               div_busy;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quo;
    logic               cor_start;
    logic signed [16:0] cor_y;
    logic               cor_done;
    logic signed [Z_W-1:0] cor_z;
    logic               in_acc;

    function automatic logic signed [23:0] sat_ang(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607)       r = 24'sd8388607;
        else if (v < -48'sd8388608) r = -24'sd8388608;
        else                        r = 24'(v);
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd32767)       r = 16'sd32767;
        else if (v < -25'sd32768) r = -16'sd32768;
        else                      r = 16'(v);
        return r;
    endfunction

    assign in_acc = i_in_valid && !o_in_stall;
    assign n_cal  = (r_cal_count == 8'd0) ? 8'd1 : r_cal_count;
    assign n_beta = 17'd65536 - 17'(r_alpha);
    assign n_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // shared multiplier operands
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (r_state)
            S_G_M1: begin
                n_ma = 32'(r_k ? r_c[0] : r_c[1]);
                n_mb = $signed({7'b0, r_fs});
            end
            S_G_M2: begin
                n_ma = 32'($signed(r_prod[28:0]));
                n_mb = $signed({2'b0, r_ms});
            end
            S_F_M1: begin
                n_ma = 32'($signed(r_t[35:16]));
                n_mb = $signed({2'b0, r_alpha});
            end
            S_F_M2: begin
                n_ma = $signed({16'b0, r_t[15:0]});
                n_mb = $signed({2'b0, r_alpha});
            end
            S_F_M3: begin
                n_ma = 32'(r_pa[r_k]);
                n_mb = $signed({1'b0, n_beta});
            end
            default: ;
        endcase
        n_mp = n_ma * n_mb;
    end

    // calibration sums, saturating
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_v = 18'(r_s[i]);
            if (i == 5) n_v = n_v - $signed({3'b0, r_grav});
            n_wide = 26'(r_sum[i]) + 26'(n_v);
            if (n_wide > 26'sd8388607)       n_sum[i] = 24'sd8388607;
            else if (n_wide < -26'sd8388608) n_sum[i] = -24'sd8388608;
            else                             n_sum[i] = 24'(n_wide);
        end
    end

    always_comb begin
        n_pmag  = (r_prod < 0) ? -r_prod : r_prod;
        n_a15   = 44'(r_rm[43:15]);
        n_a7    = 44'(r_rm[43:7]);
        n_qfin  = r_qa + 44'(r_rm[6:0] >= 7'd125);
        n_qmag  = $signed({1'b0, n_qfin[34:0]});
        n_off   = r_neg ? -$signed({1'b0, div_quo[23:0]}) : $signed({1'b0, div_quo[23:0]});
        n_round = 26'(r_pa[r_k]) + 26'sd128;
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_CAL_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NW'((r_sum[r_idx] < 0) ? -25'(r_sum[r_idx])
                                                       : 25'(r_sum[r_idx]));
                div_den   = DIV_DW'(r_cnt);
            end
            default: ;
        endcase
    end

    assign cor_start = (r_state == S_ACC_GO);
    assign cor_y     = r_k ? r_c[4] : r_c[3];

    itcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    itcf_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_y     (cor_y),
        .i_x     (r_c[5]),
        .o_done  (cor_done),
        .o_z     (cor_z)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_count <= 8'd20;
            r_grav      <= 15'd16384;
            r_fs        <= 11'd245;
            r_alpha     <= 16'd62259;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CAL_COUNT: r_cal_count <= i_cfg_data[7:0];
                REG_GRAVITY:   r_grav      <= i_cfg_data[14:0];
                REG_GYRO_FS:   r_fs        <= i_cfg_data[10:0];
                REG_ALPHA:     r_alpha     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_k         <= 1'b0;
            r_idx       <= '0;
            for (int i = 0; i < 6; i++) begin
                r_sum[i] <= '0;
                r_off[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_gang[i] <= '0;
                r_fang[i] <= '0;
            end
        end else begin
            if (n_out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_s[0] <= i_gyro_x;
                        r_s[1] <= i_gyro_y;
                        r_s[2] <= i_gyro_z;
                        r_s[3] <= i_accel_x;
                        r_s[4] <= i_accel_y;
                        r_s[5] <= i_accel_z;
                        r_ms   <= i_elapsed_ms;
                        r_state <= (r_cnt < n_cal) ? S_CAL_SUM : S_CORR;
                    end
                end
                S_CAL_SUM: begin
                    for (int i = 0; i < 6; i++) r_sum[i] <= n_sum[i];
                    r_cnt   <= r_cnt + 8'd1;
                    r_idx   <= '0;
                    r_state <= S_CAL_DIV;
                end
                S_CAL_DIV: begin
                    r_neg   <= r_sum[r_idx] < 0;
                    r_state <= S_CAL_WAIT;
                end
                S_CAL_WAIT: begin
                    if (div_done) begin
                        r_off[r_idx] <= sat16(n_off);
                        if (r_idx == 3'd5) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_CAL_DIV;
                        end
                    end
                end
                S_CORR: begin
                    for (int i = 0; i < 6; i++) r_c[i] <= 17'(r_s[i]) - 17'(r_off[i]);
                    r_k     <= 1'b0;
                    r_state <= S_ACC_GO;
                end
                S_ACC_GO: r_state <= S_ACC_WAIT;
                S_ACC_WAIT: begin
                    if (cor_done) begin
                        r_pa[r_k] <= 25'(cor_z >>> 1);
                        r_k       <= !r_k;
                        r_state   <= r_k ? S_G_M1 : S_ACC_GO;
                    end
                end
                S_G_M1: begin
                    r_prod  <= n_mp;
                    r_state <= S_G_M2;
                end
                S_G_M2: begin
                    r_prod  <= n_mp;
                    r_state <= S_G_LOAD;
                end
                S_G_LOAD: begin
                    r_neg   <= r_prod < 0;
                    r_rm    <= n_pmag[43:0];
                    r_qa    <= n_pmag[43:0];
                    r_state <= S_G_R15;
                end
                // P / 32767: a * 2^15 + b folds to a * 32767 + (a + b)
                S_G_R15: begin
                    if (n_a15 != '0) begin
                        r_qa <= r_qa + n_a15;
                        r_rm <= n_a15 + 44'(r_rm[14:0]);
                    end else begin
                        // r_qa is now P * 32768 / 32767; 32767000 = 32767 * 8 * 125
                        r_rm    <= (r_qa + 44'(r_rm == 44'd32767)) >> 3;
                        r_qa    <= '0;
                        r_state <= S_G_R125;
                    end
                end
                // divide by 125: a * 128 + b folds to a * 125 + (3a + b)
                S_G_R125: begin
                    if (n_a7 != '0) begin
                        r_qa <= r_qa + n_a7;
                        r_rm <= (n_a7 << 1) + n_a7 + 44'(r_rm[6:0]);
                    end else begin
                        // roll integrates the negated x rate
                        r_step[r_k] <= (r_neg ^ r_k) ? -n_qmag : n_qmag;
                        r_k         <= !r_k;
                        r_state     <= r_k ? S_F_T : S_G_M1;
                    end
                end
                S_F_T: begin
                    r_t         <= 36'(r_fang[r_k]) + r_step[r_k];
                    r_gang[r_k] <= sat_ang(48'(r_gang[r_k]) + 48'(r_step[r_k]));
                    r_state     <= S_F_M1;
                end
                S_F_M1: begin
                    r_prod  <= n_mp;
                    r_state <= S_F_M2;
                end
                S_F_M2: begin
                    r_acc   <= 56'(r_prod) <<< 16;
                    r_prod  <= n_mp;
                    r_state <= S_F_M3;
                end
                S_F_M3: begin
                    r_acc   <= r_acc + 56'(r_prod);
                    r_prod  <= n_mp;
                    r_state <= S_F_M4;
                end
                S_F_M4: begin
                    r_acc   <= r_acc + 56'(r_prod);
                    r_state <= S_F_SAT;
                end
                S_F_SAT: begin
                    r_fang[r_k] <= sat_ang(48'(r_acc >>> 16));
                    r_ar[r_k]   <= sat16(25'($signed(n_round[25:8])));
                    r_k         <= !r_k;
                    r_state     <= r_k ? S_DONE : S_F_T;
                end
                S_DONE: begin
                    if (n_out_load) begin
                        r_o[0]      <= r_ar[0];
                        r_o[1]      <= r_ar[1];
                        r_o[2]      <= r_gang[0][23:8];
                        r_o[3]      <= r_gang[1][23:8];
                        r_o[4]      <= r_fang[0][23:8];
                        r_o[5]      <= r_fang[1][23:8];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_pitch_accel = r_o[0];
    assign o_roll_accel  = r_o[1];
    assign o_pitch_gyro  = r_o[2];
    assign o_roll_gyro   = r_o[3];
    assign o_pitch_fused = r_o[4];
    assign o_roll_fused  = r_o[5];

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("accepted word did not start work");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the done state");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_cal_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CAL_SUM |=> r_cnt == $past(r_cnt) + 8'd1)
        else $error("calibration count did not advance");

endmodule

[dv/itcf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itcf_checker
// Watches the sample, angle and register channels of the tilt filter, keeps
// its own calibration and filter state, and compares each angle word
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module itcf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic        [15:0] i_elapsed_ms,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_pitch_accel,
    input  logic signed [15:0] i_roll_accel,
    input  logic signed [15:0] i_pitch_gyro,
    input  logic signed [15:0] i_roll_gyro,
    input  logic signed [15:0] i_pitch_fused,
    input  logic signed [15:0] i_roll_fused,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic        [7:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import itcf_pkg::*;

    localparam int      CORDIC_STEPS = 16;
    localparam longint  ANGLE_MAX    = 64'sd32767 * 256 + 255;
    localparam longint  ANGLE_MIN    = -64'sd32768 * 256;
    localparam longint  SUM_MAX      = 64'sd8388607;
    localparam longint  SUM_MIN      = -64'sd8388608;

    typedef struct {
        shortint pitch_accel;
        shortint roll_accel;
        shortint pitch_gyro;
        shortint roll_gyro;
        shortint pitch_fused;
        shortint roll_fused;
    } t_tilt_word;

    // atan(2^-i) in Q16 degrees
    localparam longint ATAN_TAB [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic [7:0]  cal_count_q;
    logic [14:0] gravity_q;
    logic [10:0] full_scale_q;
    logic [15:0] alpha_q;
    longint      bias_sums [6];
    longint      biases [6];
    int          cal_taken;
    longint      gyro_ang [2];
    longint      fused_ang [2];
    t_tilt_word  angles_due [$];

    assign o_pending = angles_due.size();

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint tilt_q16(longint y_in, longint x_in);
        longint x, y, z, dx, dy, t;
        x = x_in * 256;
        y = y_in * 256;
        z = 0;
        if (x_in == 0 && y_in == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 90 * 65536;
            end else begin
                x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x += dy; y -= dx; z += ATAN_TAB[i];
            end else begin
                x -= dy; y += dx; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint rate_step(longint rate, longint ms);
        return (rate * longint'(full_scale_q) * ms * 32768) / 64'sd32767000;
    endfunction

    function automatic longint blend(longint f, longint stp, longint acc);
        longint m;
        m = (f + stp) * longint'(alpha_q) + acc * (65536 - longint'(alpha_q));
        return clip(m >>> 16, ANGLE_MIN, ANGLE_MAX);
    endfunction

    task automatic take_sample();
        longint     s [6];
        longint     c [6];
        longint     pa, ra, sp, sr;
        int         cal;
        t_tilt_word w;
        s[0] = i_gyro_x;  s[1] = i_gyro_y;  s[2] = i_gyro_z;
        s[3] = i_accel_x; s[4] = i_accel_y; s[5] = i_accel_z;
        cal = (cal_count_q == 0) ? 1 : int'(cal_count_q);
        if (cal_taken < cal) begin
            s[5] -= longint'(gravity_q);
            cal_taken++;
            for (int i = 0; i < 6; i++) begin
                bias_sums[i] = clip(bias_sums[i] + s[i], SUM_MIN, SUM_MAX);
                biases[i] = clip(bias_sums[i] / cal_taken, -32768, 32767);
            end
            return;
        end
        for (int i = 0; i < 6; i++) c[i] = s[i] - biases[i];
        pa = tilt_q16(c[3], c[5]) >>> 1;
        ra = tilt_q16(c[4], c[5]) >>> 1;
        sp = rate_step(c[1], longint'(i_elapsed_ms));
        sr = -rate_step(c[0], longint'(i_elapsed_ms));
        gyro_ang[0]  = clip(gyro_ang[0] + sp, ANGLE_MIN, ANGLE_MAX);
        gyro_ang[1]  = clip(gyro_ang[1] + sr, ANGLE_MIN, ANGLE_MAX);
        fused_ang[0] = blend(fused_ang[0], sp, pa);
        fused_ang[1] = blend(fused_ang[1], sr, ra);
        w.pitch_accel = shortint'(clip((pa + 128) >>> 8, -32768, 32767));
        w.roll_accel  = shortint'(clip((ra + 128) >>> 8, -32768, 32767));
        w.pitch_gyro  = shortint'(gyro_ang[0] >>> 8);
        w.roll_gyro   = shortint'(gyro_ang[1] >>> 8);
        w.pitch_fused = shortint'(fused_ang[0] >>> 8);
        w.roll_fused  = shortint'(fused_ang[1] >>> 8);
        angles_due.push_back(w);
    endtask

    task automatic report(string what, int got, int want);
        $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_word();
        t_tilt_word w;
        if (angles_due.size() == 0) begin
            report("unexpected angle word, pitch_accel", i_pitch_accel, 0);
            return;
        end
        w = angles_due.pop_front();
        if (i_pitch_accel != w.pitch_accel) report("pitch_accel", i_pitch_accel, w.pitch_accel);
        if (i_roll_accel != w.roll_accel)   report("roll_accel", i_roll_accel, w.roll_accel);
        if (i_pitch_gyro != w.pitch_gyro)   report("pitch_gyro", i_pitch_gyro, w.pitch_gyro);
        if (i_roll_gyro != w.roll_gyro)     report("roll_gyro", i_roll_gyro, w.roll_gyro);
        if (i_pitch_fused != w.pitch_fused) report("pitch_fused", i_pitch_fused, w.pitch_fused);
        if (i_roll_fused != w.roll_fused)   report("roll_fused", i_roll_fused, w.roll_fused);
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_count_q  = 8'd20;
            gravity_q    = 15'd16384;
            full_scale_q = 11'd245;
            alpha_q      = 16'd62259;
            for (int i = 0; i < 6; i++) begin
                bias_sums[i] = 0;
                biases[i] = 0;
            end
            cal_taken = 0;
            gyro_ang  = '{0, 0};
            fused_ang = '{0, 0};
            angles_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_word();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CAL_COUNT: cal_count_q  = i_cfg_data[7:0];
                    REG_GRAVITY:   gravity_q    = i_cfg_data[14:0];
                    REG_GYRO_FS:   full_scale_q = i_cfg_data[10:0];
                    REG_ALPHA:     alpha_q      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) take_sample();
        end
    end

endmodule

[dv/imu_tilt_complementary_filter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_test
// Drives calibration and filter samples through the tilt filter under several
// register settings, with random gaps and output stalls; the checker predicts
// and compares every angle word.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter_test;
    import itcf_pkg::*;

    localparam int SETTLE_CYCLES = 900;
    localparam int IDLE_LIMIT    = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_gyro_x = '0;
    logic signed [15:0] i_gyro_y = '0;
    logic signed [15:0] i_gyro_z = '0;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_accel_z = '0;
    logic        [15:0] i_elapsed_ms = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_pitch_accel, o_roll_accel, o_pitch_gyro;
    logic signed [15:0] o_roll_gyro, o_pitch_fused, o_roll_fused;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic        [7:0]  i_cfg_index = '0;
    logic        [15:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit quiet = 1'b0;

    always #5 i_clk = ~i_clk;

    imu_tilt_complementary_filter dut (.*);

    itcf_checker u_checker (
        .i_in_stall (o_in_stall),
        .i_out_valid(o_out_valid),
        .i_pitch_accel(o_pitch_accel),
        .i_roll_accel (o_roll_accel),
        .i_pitch_gyro (o_pitch_gyro),
        .i_roll_gyro  (o_roll_gyro),
        .i_pitch_fused(o_pitch_fused),
        .i_roll_fused (o_roll_fused),
        .i_cfg_ready(o_cfg_ready),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .*
    );

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 9);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] data);
        bit rdy;
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        forever begin
            #1 rdy = o_cfg_ready;
            @(posedge i_clk);
            if (rdy) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_sample(logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                               logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] ms);
        bit stl;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 9) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        {i_gyro_x, i_gyro_y, i_gyro_z} = {gx, gy, gz};
        {i_accel_x, i_accel_y, i_accel_z, i_elapsed_ms} = {ax, ay, az, ms};
        forever begin
            #1 stl = o_in_stall;
            @(posedge i_clk);
            if (!stl) break;
            @(negedge i_clk);
        end
    endtask

    // wait for every predicted word, then let a calibration sample finish
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_sample();
        int mode;
        mode = $urandom_range(9);
        if (mode < 3) begin
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            send_sample(16'($signed($urandom_range(1000)) - 500),
                        16'($signed($urandom_range(1000)) - 500),
                        16'($signed($urandom_range(1000)) - 500),
                        16'($signed($urandom_range(40000)) - 20000),
                        16'($signed($urandom_range(40000)) - 20000),
                        16'($signed($urandom_range(40000)) - 20000),
                        (mode == 9) ? 16'($urandom) : 16'($urandom_range(200)));
        end
    endtask

    // register settings per phase: cal_count, gravity, full scale, alpha
    logic [15:0] plan [8][4] = '{
        '{16'd1,   16'd16384, 16'd245,  16'd62259},
        '{16'd5,   16'd0,     16'd2000, 16'd65535},
        '{16'd0,   16'd32767, 16'd1,    16'd0},
        '{16'd30,  16'd16384, 16'd500,  16'd32768},
        '{16'd60,  16'd1000,  16'd2000, 16'd62259},
        '{16'd120, 16'd20000, 16'd245,  16'd65000},
        '{16'd255, 16'd16384, 16'd1000, 16'd1},
        '{16'd20,  16'd8192,  16'd2000, 16'd65535}
    };

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: one zero calibration sample leaves all offsets at zero
        write_reg(REG_CAL_COUNT, 16'd1);
        write_reg(REG_GRAVITY, 16'd0);
        write_reg(REG_GYRO_FS, 16'd2000);
        write_reg(REG_ALPHA, 16'd62259);
        send_sample(0, 0, 0, 0, 0, 0, 0);
        send_sample(0, 0, 0, 0, 0, 0, 16'd100);            // x and z both zero
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'hffff);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'hffff);
        send_sample(16'h8000, 16'h7fff, 0, 16'h7fff, 16'h8000, 16'h8000, 16'hffff);
        send_sample(16'h7fff, 16'h8000, 0, 0, 16'd100, 16'h8000, 16'd10);
        send_sample(0, 0, 0, 16'd100, 0, 0, 16'd10);
        send_sample(0, 0, 0, 16'hff9c, 0, 0, 16'd10);
        send_sample(0, 0, 0, 0, 16'd500, 16'hfc18, 16'd1);   // negative z, y above
        send_sample(0, 0, 0, 16'hfe0c, 16'hfe0c, 16'hfc18, 16'd1);
        send_sample(0, 0, 0, 16'd1, 16'hffff, 16'd16384, 16'd50);
        for (int i = 0; i < 6; i++) begin
            send_sample(16'h7fff, 16'h8000, 0, 0, 0, 16'd16384, 16'hffff);
        end
        drain();
        write_reg(8'd4, 16'hffff);                          // no such register
        write_reg(8'd255, 16'h0000);

        for (int p = 0; p < 8; p++) begin
            quiet = (p == 3);
            write_reg(REG_CAL_COUNT, plan[p][0]);
            write_reg(REG_GRAVITY, plan[p][1]);
            write_reg(REG_GYRO_FS, plan[p][2]);
            write_reg(REG_ALPHA, plan[p][3]);
            write_reg(8'($urandom_range(255, 4)), 16'($urandom));
            for (int n = 0; n < 175; n++) begin
                random_sample();
                if (n == 90) drain();
            end
            drain();
        end
        quiet = 1'b0;

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
